// ----- design/strd_pkg.sv -----
// ----------------------------------------------------------------------------
// strd_pkg - shared types and constants for the sorted table block
// Action and status codes, sequencer states, and the result record that
// travels from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package strd_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int COUNT_OUT_W  = 7;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [COUNT_OUT_W-1:0]   count_out_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_DEL_RD,
    ST_DEL_CMP,
    ST_DONE
  } state_t;

  // compare unit verdict
  typedef struct packed {
    logic below;  // x < lo
    logic above;  // x > hi
  } cmp_res_t;

  typedef struct packed {
    logic [1:0] status;
    count_out_t removed_count;
    count_out_t entry_count;
    logic       is_empty;
    data_t      smallest;
    data_t      largest;
  } result_t;

endpackage

// ----- design/strd_in_if.sv -----
// ----------------------------------------------------------------------------
// strd_in_if - action channel of the sorted table block
// Valid/ready channel carrying one action with its operands.
// ----------------------------------------------------------------------------
interface strd_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic signed [31:0]  item_value;
  logic signed [31:0]  range_low;
  logic signed [31:0]  range_high;

  modport source (output valid, action, item_value, range_low, range_high, input ready);
  modport sink   (input valid, action, item_value, range_low, range_high, output ready);
endinterface

// ----- design/strd_out_if.sv -----
// ----------------------------------------------------------------------------
// strd_out_if - result channel of the sorted table block
// Valid/ready channel carrying one result per action.
// ----------------------------------------------------------------------------
interface strd_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [6:0]          removed_count;
  logic [6:0]          entry_count;
  logic                is_empty;
  logic signed [31:0]  smallest;
  logic signed [31:0]  largest;

  modport source (output valid, status, removed_count, entry_count, is_empty,
                  smallest, largest, input ready);
  modport sink   (input valid, status, removed_count, entry_count, is_empty,
                  smallest, largest, output ready);
endinterface

// ----- design/strd_cmp.sv -----
// ----------------------------------------------------------------------------
// strd_cmp - shared signed compare unit
// Checks one operand against a lower and an upper bound.
// ----------------------------------------------------------------------------
module strd_cmp (
  input  strd_pkg::data_t    x,
  input  strd_pkg::data_t    lo,
  input  strd_pkg::data_t    hi,
  output strd_pkg::cmp_res_t res
);

  assign res.below = (x < lo);
  assign res.above = (x > hi);

endmodule

// ----- design/strd_seq.sv -----
// ----------------------------------------------------------------------------
// strd_seq - sequencer, table memory and bookkeeping
// Walks the table one entry at a time (read state, then compare state) for
// insert shifting and range-delete compaction, using the shared compare unit.
// ----------------------------------------------------------------------------
module strd_seq #(
  parameter int CAPACITY = strd_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  strd_in_if.sink            in_chan,
  input  logic               out_free,
  output logic               res_push,
  output strd_pkg::result_t  res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);

  strd_pkg::state_t  state_r, state_nxt;
  logic [1:0]        action_r, action_nxt;
  strd_pkg::data_t   value_r, value_nxt;
  strd_pkg::data_t   lo_r, lo_nxt;
  strd_pkg::data_t   hi_r, hi_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  wr_r, wr_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [CNT_W-1:0]  removed_r, removed_nxt;
  strd_pkg::data_t   first_r, first_nxt;
  strd_pkg::data_t   last_r, last_nxt;

  strd_pkg::data_t   mem [CAPACITY];
  strd_pkg::data_t   rdata_r;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  strd_pkg::data_t   wr_data;

  strd_pkg::data_t   cmp_x, cmp_lo, cmp_hi;
  strd_pkg::cmp_res_t cmp;

  logic              in_xfer;
  logic [CNT_W-1:0]  idx_dec, idx_inc, wr_inc, kept_total;
  logic              full, keep, del_last;

  assign in_xfer    = in_chan.valid && in_chan.ready;
  assign idx_dec    = idx_r - CNT_W'(1);
  assign idx_inc    = idx_r + CNT_W'(1);
  assign wr_inc     = wr_r + CNT_W'(1);
  assign full       = (count_r == CNT_W'(CAPACITY));
  assign keep       = cmp.below || cmp.above;
  assign del_last   = (idx_inc == count_r);
  assign kept_total = keep ? wr_inc : wr_r;

  strd_cmp u_cmp (
    .x   (cmp_x),
    .lo  (cmp_lo),
    .hi  (cmp_hi),
    .res (cmp)
  );

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      strd_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = strd_pkg::ST_CHECK;
      end
      strd_pkg::ST_CHECK: begin
        unique case (action_r)
          strd_pkg::ACT_INSERT: begin
            if (full) state_nxt = strd_pkg::ST_DONE;
            else if (count_r == '0) state_nxt = strd_pkg::ST_INS_PUT;
            else state_nxt = strd_pkg::ST_INS_RD;
          end
          strd_pkg::ACT_DELETE: begin
            if (cmp.above || count_r == '0) state_nxt = strd_pkg::ST_DONE;
            else state_nxt = strd_pkg::ST_DEL_RD;
          end
          default: state_nxt = strd_pkg::ST_DONE;
        endcase
      end
      strd_pkg::ST_INS_RD:  state_nxt = strd_pkg::ST_INS_CMP;
      strd_pkg::ST_INS_CMP: begin
        if (!cmp.above) state_nxt = strd_pkg::ST_DONE;
        else if (idx_r == CNT_W'(1)) state_nxt = strd_pkg::ST_INS_PUT;
        else state_nxt = strd_pkg::ST_INS_RD;
      end
      strd_pkg::ST_INS_PUT: state_nxt = strd_pkg::ST_DONE;
      strd_pkg::ST_DEL_RD:  state_nxt = strd_pkg::ST_DEL_CMP;
      strd_pkg::ST_DEL_CMP: begin
        if (del_last) state_nxt = strd_pkg::ST_DONE;
        else state_nxt = strd_pkg::ST_DEL_RD;
      end
      strd_pkg::ST_DONE: begin
        if (out_free) state_nxt = strd_pkg::ST_IDLE;
      end
      default: state_nxt = strd_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake, memory port, compare operands
  always_comb begin
    in_chan.ready = (state_r == strd_pkg::ST_IDLE);
    res_push      = (state_r == strd_pkg::ST_DONE) && out_free;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = idx_r[AW-1:0];
    wr_data       = value_r;
    cmp_x         = rdata_r;
    cmp_lo        = lo_r;
    cmp_hi        = hi_r;
    unique case (state_r)
      strd_pkg::ST_CHECK: begin
        cmp_x = lo_r;  // range sanity: low above high
      end
      strd_pkg::ST_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_dec[AW-1:0];
      end
      strd_pkg::ST_INS_CMP: begin
        cmp_lo  = value_r;
        cmp_hi  = value_r;
        wr_en   = 1'b1;
        wr_data = cmp.above ? rdata_r : value_r;
      end
      strd_pkg::ST_INS_PUT: begin
        wr_en = 1'b1;
      end
      strd_pkg::ST_DEL_RD: begin
        rd_en = 1'b1;
      end
      strd_pkg::ST_DEL_CMP: begin
        wr_en   = keep;
        wr_addr = wr_r[AW-1:0];
        wr_data = rdata_r;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    action_nxt  = action_r;
    value_nxt   = value_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    wr_nxt      = wr_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    case (state_r)
      strd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          action_nxt  = in_chan.action;
          value_nxt   = in_chan.item_value;
          lo_nxt      = in_chan.range_low;
          hi_nxt      = in_chan.range_high;
          status_nxt  = strd_pkg::STAT_DONE;
          removed_nxt = '0;
        end
      end
      strd_pkg::ST_CHECK: begin
        case (action_r)
          strd_pkg::ACT_INSERT: begin
            if (full) status_nxt = strd_pkg::STAT_FULL;
            else idx_nxt = count_r;
          end
          strd_pkg::ACT_DELETE: begin
            if (cmp.above) status_nxt = strd_pkg::STAT_RANGE;
            idx_nxt = '0;
            wr_nxt  = '0;
          end
          strd_pkg::ACT_CLEAR: begin
            removed_nxt = count_r;
            count_nxt   = '0;
          end
          default: ;
        endcase
      end
      strd_pkg::ST_INS_CMP, strd_pkg::ST_INS_PUT: begin
        if (state_r == strd_pkg::ST_INS_CMP && cmp.above) begin
          idx_nxt = idx_dec;
        end else begin
          // new value lands at idx_r
          if (idx_r == '0) first_nxt = value_r;
          if (idx_r == count_r) last_nxt = value_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      strd_pkg::ST_DEL_CMP: begin
        if (keep) begin
          if (wr_r == '0) first_nxt = rdata_r;
          last_nxt = rdata_r;
          wr_nxt   = wr_inc;
        end
        idx_nxt = idx_inc;
        if (del_last) begin
          count_nxt   = kept_total;
          removed_nxt = count_r - kept_total;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= strd_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r  <= action_nxt;
    value_r   <= value_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    idx_r     <= idx_nxt;
    wr_r      <= wr_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
  end

  always_comb begin
    res.status        = status_r;
    res.removed_count = strd_pkg::count_out_t'(removed_r);
    res.entry_count   = strd_pkg::count_out_t'(count_r);
    res.is_empty      = (count_r == '0);
    res.smallest      = (count_r == '0) ? '0 : first_r;
    res.largest       = (count_r == '0) ? '0 : last_r;
  end

endmodule

// ----- design/sorted_table_range_delete.sv -----
// ----------------------------------------------------------------------------
// sorted_table_range_delete - ascending sorted table with range delete
// Keeps up to CAPACITY signed Q24.8 values in order; insert, inclusive
// range delete and clear, one result per action.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  in_chan   in   valid/ready            action, item_value, range_low, range_high
//  out_chan  out  valid/ready            status, removed_count, entry_count,
//                                        is_empty, smallest, largest
//
// Sequencing: one action is worked at a time. Insert reads entries from the
// top down through the table memory and the compare unit, shifting each one
// above the new value up one place, then writes the new value; range delete
// reads every entry held and compacts the kept ones; clear, refused and
// unused actions go straight to the result. The longest action is a range
// delete on a full table.
// Reset: synchronous, clears the sequencer, the entry count and the output
// valid only; the table memory is never cleared, entries at or above the
// count are not read.
// Stalls: the result sits in an output register, so the next action is
// taken while the previous result waits for its transfer.
// ----------------------------------------------------------------------------
module sorted_table_range_delete #(
  parameter int CAPACITY = strd_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  strd_in_if.sink     in_chan,
  strd_out_if.source  out_chan
);

  logic               out_valid_r, out_valid_nxt;
  strd_pkg::result_t  out_res_r;
  strd_pkg::result_t  seq_res;
  logic               seq_push;
  logic               out_free;

  // output register free when empty or draining this cycle
  assign out_free = !out_valid_r || out_chan.ready;

  strd_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_free (out_free),
    .res_push (seq_push),
    .res      (seq_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (seq_push) out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_push) begin
      out_res_r <= seq_res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_res_r.status;
  assign out_chan.removed_count = out_res_r.removed_count;
  assign out_chan.entry_count   = out_res_r.entry_count;
  assign out_chan.is_empty      = out_res_r.is_empty;
  assign out_chan.smallest      = out_res_r.smallest;
  assign out_chan.largest       = out_res_r.largest;

`ifndef SYNTHESIS
  // block goes busy right after taking an action
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input ready right after a transfer");

  // a result is only loaded into a free output register
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    seq_push |-> (!out_valid_r || out_chan.ready))
    else $error("result overwrote a pending transfer");

  // refused actions remove nothing
  a_refused_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != strd_pkg::STAT_DONE)
      |-> (out_chan.removed_count == '0))
    else $error("refused action reports removals");

  // empty table reports zero extremes
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.is_empty)
      |-> (out_chan.smallest == '0 && out_chan.largest == '0))
    else $error("empty table with nonzero extremes");
`endif

endmodule

// ----- dv/sorted_table_range_delete_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_range_delete_tb - self-checking bench for the sorted table
// Drives insert, range delete, clear and the spare action code through the
// action channel. A behavioral copy of the table predicts every result, and
// each result transfer is checked field by field against the oldest
// prediction. Sender bursts, receiver stall patterns and one long receiver
// hold-off keep both handshakes busy on every phase of the block's work.
// ----------------------------------------------------------------------------
module sorted_table_range_delete_tb;

  localparam int TABLE_DEPTH   = strd_pkg::CAPACITY_DEF;
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 4;
  localparam int RANDOM_ITEMS  = 480;
  // worst action is a range delete on a full table
  localparam int DRAIN_CYCLES  = 2 * TABLE_DEPTH + 20;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PRESSURE_HOLD = 300;
  localparam int MAX_REPORTS   = 10;

  // action code two bits can carry but the block does not define
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam strd_pkg::data_t VAL_MIN = {1'b1, {(strd_pkg::DATA_W-1){1'b0}}};
  localparam strd_pkg::data_t VAL_MAX = {1'b0, {(strd_pkg::DATA_W-1){1'b1}}};
  localparam strd_pkg::data_t VAL_ONE = strd_pkg::data_t'(256);  // 1.0 in Q24.8

  logic clk;
  logic rst_n;

  strd_in_if  in_chan ();
  strd_out_if out_chan ();

  sorted_table_range_delete #(
    .CAPACITY (TABLE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // --------------------------------------------------------------------------
  // Shadow of the table contents and the results still owed by the block
  // --------------------------------------------------------------------------
  strd_pkg::data_t   tbl_vals[$];         // ascending, equal values in arrival order
  strd_pkg::result_t pending_results[$];  // one per accepted action, oldest first

  int     mismatch_count;
  int     checked_count;
  int     sent_count;
  int     unused_count;
  int     full_refusals;
  int     range_refusals;
  int     peak_fill;
  int     max_removed;
  int     burst_left;           // transfers left before the sender idles
  int     steady_sender;        // 1: no idle gaps between transfers
  int     hold_request;         // cycles of receiver hold-off asked by a test
  longint cycle_count;

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Table predictor: applies one accepted action to the shadow table and
  // returns the result the block must produce for it.
  // --------------------------------------------------------------------------
  function automatic strd_pkg::result_t table_apply(logic [1:0] act,
                                                    strd_pkg::data_t value,
                                                    strd_pkg::data_t lo,
                                                    strd_pkg::data_t hi);
    strd_pkg::result_t r;
    strd_pkg::data_t   kept[$];
    int                pos;
    r = '0;
    r.status = strd_pkg::STAT_DONE;
    case (act)
      strd_pkg::ACT_INSERT: begin
        if (tbl_vals.size() >= TABLE_DEPTH) begin
          r.status = strd_pkg::STAT_FULL;
          full_refusals++;
        end else begin
          // new value goes after any entries that compare equal
          pos = 0;
          while (pos < tbl_vals.size() && tbl_vals[pos] <= value) pos++;
          tbl_vals.insert(pos, value);
        end
      end
      strd_pkg::ACT_DELETE: begin
        if (lo > hi) begin
          r.status = strd_pkg::STAT_RANGE;
          range_refusals++;
        end else begin
          // both bounds inclusive, signed order
          foreach (tbl_vals[i])
            if (tbl_vals[i] < lo || tbl_vals[i] > hi) kept.push_back(tbl_vals[i]);
          r.removed_count = strd_pkg::count_out_t'(tbl_vals.size() - kept.size());
          tbl_vals = kept;
        end
      end
      strd_pkg::ACT_CLEAR: begin
        r.removed_count = strd_pkg::count_out_t'(tbl_vals.size());
        tbl_vals.delete();
      end
      default: begin
        unused_count++;  // spare code leaves the table as it is
      end
    endcase
    r.entry_count = strd_pkg::count_out_t'(tbl_vals.size());
    r.is_empty    = (tbl_vals.size() == 0);
    if (tbl_vals.size() != 0) begin
      r.smallest = tbl_vals[0];
      r.largest  = tbl_vals[tbl_vals.size() - 1];
    end
    if (tbl_vals.size() > peak_fill) peak_fill = tbl_vals.size();
    if (int'(r.removed_count) > max_removed) max_removed = r.removed_count;
    return r;
  endfunction

  function automatic string fmt_result(strd_pkg::result_t r);
    return $sformatf("status=%0d removed=%0d count=%0d empty=%0d smallest=%0d largest=%0d",
                     r.status, r.removed_count, r.entry_count, r.is_empty,
                     r.smallest, r.largest);
  endfunction

  function automatic void report_error(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] ERROR %s", $time, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every result transfer is compared with the oldest
  // prediction. Handshake signals are sampled as they stood before the edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    strd_pkg::result_t got;
    strd_pkg::result_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.status        = out_chan.status;
      got.removed_count = out_chan.removed_count;
      got.entry_count   = out_chan.entry_count;
      got.is_empty      = out_chan.is_empty;
      got.smallest      = out_chan.smallest;
      got.largest       = out_chan.largest;
      if (pending_results.size() == 0) begin
        report_error($sformatf("result with no action outstanding: %s", fmt_result(got)));
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got.status !== want.status || got.removed_count !== want.removed_count ||
            got.entry_count !== want.entry_count || got.is_empty !== want.is_empty ||
            got.smallest !== want.smallest || got.largest !== want.largest) begin
          report_error($sformatf("result %0d mismatch\n  exp %s\n  act %s",
                                 checked_count, fmt_result(want), fmt_result(got)));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: changes stall pattern every so often; a test can ask for one
  // long hold-off, which this process counts down on its own.
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    int phase;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_chan.ready <= 1'b1;                        // no stalls
          1:       out_chan.ready <= 1'($urandom_range(0, 1));
          2:       out_chan.ready <= ($urandom_range(0, 3) != 0);
          default: out_chan.ready <= ((phase % 7) > 2);           // fixed rhythm
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: one transfer per call. Valid stays high across back-to-back
  // transfers; between bursts it drops for a random number of cycles.
  // Called only right after a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_action(logic [1:0] act, strd_pkg::data_t value,
                             strd_pkg::data_t lo, strd_pkg::data_t hi);
    int gap;
    if (burst_left == 0 && steady_sender == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    in_chan.valid      <= 1'b1;
    in_chan.action     <= act;
    in_chan.item_value <= value;
    in_chan.range_low  <= lo;
    in_chan.range_high <= hi;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pending_results.push_back(table_apply(act, value, lo, hi));
    sent_count++;
  endtask

  // drop valid, wait for every owed result, then let the block settle
  task automatic wait_for_drain();
    int waited;
    in_chan.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending_results.size() != 0 && waited < CYCLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Value and range pickers
  // --------------------------------------------------------------------------
  function automatic strd_pkg::data_t rnd_word();
    return strd_pkg::data_t'($urandom);
  endfunction

  // mix of small fixed-point integers (lots of duplicates), extremes,
  // copies of held entries and raw 32-bit words
  function automatic strd_pkg::data_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return strd_pkg::data_t'((int'($urandom_range(0, 15)) - 8) * 256);
      4: begin
        case ($urandom_range(0, 4))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          3:       return strd_pkg::data_t'(-1);
          default: return VAL_ONE;
        endcase
      end
      5: begin
        if (tbl_vals.size() != 0) return tbl_vals[$urandom_range(0, tbl_vals.size() - 1)];
        return rnd_word();
      end
      default: return rnd_word();
    endcase
  endfunction

  // mostly bounds taken from held entries so deletes hit something; some
  // inverted ranges and some raw words in either order
  task automatic pick_range(output strd_pkg::data_t lo, output strd_pkg::data_t hi);
    int              r;
    int              i;
    int              j;
    strd_pkg::data_t t;
    r = $urandom_range(0, 19);
    if (tbl_vals.size() != 0 && r < 12) begin
      i  = $urandom_range(0, tbl_vals.size() - 1);
      j  = $urandom_range(i, tbl_vals.size() - 1);
      lo = tbl_vals[i];
      hi = tbl_vals[j];
      // step just outside the held value on one side now and then
      if (r < 3 && lo != VAL_MIN) lo = lo - 1;
      if (r == 3 && hi != VAL_MAX) hi = hi + 1;
    end else if (r < 15) begin
      lo = pick_value();
      hi = pick_value();
      if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
    end else if (r < 18) begin
      // low above high: must be refused
      lo = pick_value();
      hi = pick_value();
      if (lo < hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      if (lo == hi) begin
        if (lo == VAL_MIN) lo = lo + 1;
        else hi = lo - 1;
      end
    end else begin
      lo = rnd_word();
      hi = rnd_word();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // edges of every action on an empty and a small table
  task automatic test_directed_edges();
    send_action(strd_pkg::ACT_DELETE, rnd_word(), VAL_MIN, VAL_MAX);   // delete on empty
    send_action(strd_pkg::ACT_CLEAR,  rnd_word(), rnd_word(), rnd_word());
    send_action(ACT_UNUSED, rnd_word(), rnd_word(), rnd_word());
    send_action(strd_pkg::ACT_DELETE, rnd_word(), VAL_MAX, VAL_MIN);   // inverted, extreme
    send_action(strd_pkg::ACT_INSERT, VAL_MAX, rnd_word(), rnd_word());
    send_action(strd_pkg::ACT_INSERT, VAL_MIN, rnd_word(), rnd_word());
    send_action(strd_pkg::ACT_INSERT, '0, rnd_word(), rnd_word());
    send_action(strd_pkg::ACT_INSERT, '0, rnd_word(), rnd_word());      // equal value
    send_action(strd_pkg::ACT_INSERT, strd_pkg::data_t'(-1), rnd_word(), rnd_word());
    send_action(strd_pkg::ACT_INSERT, VAL_ONE, rnd_word(), rnd_word());
    send_action(ACT_UNUSED, rnd_word(), rnd_word(), rnd_word());
    send_action(strd_pkg::ACT_DELETE, rnd_word(), VAL_ONE, '0);        // low above high
    send_action(strd_pkg::ACT_DELETE, rnd_word(), 2 * VAL_ONE, 4 * VAL_ONE);  // no match
    send_action(strd_pkg::ACT_DELETE, rnd_word(), '0, '0);             // both zeros go
    send_action(strd_pkg::ACT_DELETE, rnd_word(), VAL_MIN, VAL_MIN);
    send_action(strd_pkg::ACT_DELETE, rnd_word(), VAL_ONE, VAL_MAX);
    send_action(strd_pkg::ACT_DELETE, rnd_word(), strd_pkg::data_t'(-1),
                strd_pkg::data_t'(-1));                                // empties
    send_action(strd_pkg::ACT_INSERT, -VAL_ONE, rnd_word(), rnd_word());
    send_action(strd_pkg::ACT_INSERT, 3 * VAL_ONE, rnd_word(), rnd_word());
    send_action(strd_pkg::ACT_CLEAR,  rnd_word(), rnd_word(), rnd_word());
    wait_for_drain();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the output register fills and the action channel stalls
  task automatic test_input_backpressure();
    hold_request  = PRESSURE_HOLD;
    steady_sender = 1;
    repeat (12) send_action(strd_pkg::ACT_INSERT, pick_value(), rnd_word(), rnd_word());
    steady_sender = 0;
    send_action(strd_pkg::ACT_CLEAR, rnd_word(), rnd_word(), rnd_word());
    wait_for_drain();
  endtask

  // descending fill puts every insert at the front (longest shifts), then
  // inserts into the full table and a delete that takes everything
  task automatic test_fill_descending();
    strd_pkg::data_t v;
    int              step;
    step = $urandom_range(1, 1 << 24);
    v    = VAL_MAX;
    send_action(strd_pkg::ACT_CLEAR, rnd_word(), rnd_word(), rnd_word());
    repeat (TABLE_DEPTH) begin
      send_action(strd_pkg::ACT_INSERT, v, rnd_word(), rnd_word());
      v = v - step;
    end
    send_action(strd_pkg::ACT_INSERT, VAL_MIN, rnd_word(), rnd_word());   // refused
    send_action(strd_pkg::ACT_INSERT, VAL_MAX, rnd_word(), rnd_word());   // refused
    send_action(strd_pkg::ACT_DELETE, rnd_word(), VAL_MIN, VAL_MAX);      // removes all
    send_action(strd_pkg::ACT_INSERT, pick_value(), rnd_word(), rnd_word());
    send_action(strd_pkg::ACT_CLEAR, rnd_word(), rnd_word(), rnd_word());
    wait_for_drain();
  endtask

  // episodes of fill / delete / clear with random content; one in six
  // fills past capacity, the rest stay small to keep the run short
  task automatic test_random_episodes();
    int              stop_at;
    int              ins_goal;
    bit              deep;
    strd_pkg::data_t lo;
    strd_pkg::data_t hi;
    stop_at = sent_count + RANDOM_ITEMS;
    while (sent_count < stop_at) begin
      deep     = ($urandom_range(0, 5) == 0);
      ins_goal = deep ? TABLE_DEPTH + $urandom_range(1, 4) : $urandom_range(1, 24);
      for (int k = 0; k < ins_goal; k++) begin
        send_action(strd_pkg::ACT_INSERT, pick_value(), rnd_word(), rnd_word());
        if (!deep && $urandom_range(0, 5) == 0) begin
          pick_range(lo, hi);
          send_action(strd_pkg::ACT_DELETE, rnd_word(), lo, hi);
        end
        if ($urandom_range(0, 30) == 0)
          send_action(ACT_UNUSED, rnd_word(), rnd_word(), rnd_word());
      end
      repeat ($urandom_range(0, 3)) begin
        pick_range(lo, hi);
        send_action(strd_pkg::ACT_DELETE, rnd_word(), lo, hi);
      end
      case ($urandom_range(0, 3))
        0, 1:    send_action(strd_pkg::ACT_CLEAR, rnd_word(), rnd_word(), rnd_word());
        2:       send_action(strd_pkg::ACT_DELETE, rnd_word(), VAL_MIN, VAL_MAX);
        default: ;  // carry the table into the next episode
      endcase
    end
    wait_for_drain();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    checked_count  = 0;
    sent_count     = 0;
    unused_count   = 0;
    full_refusals  = 0;
    range_refusals = 0;
    peak_fill      = 0;
    max_removed    = 0;
    burst_left     = 0;
    steady_sender  = 0;
    hold_request   = 0;
    cycle_count    = 0;

    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.action     <= strd_pkg::ACT_INSERT;
    in_chan.item_value <= '0;
    in_chan.range_low  <= '0;
    in_chan.range_high <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_input_backpressure();
    test_fill_descending();
    test_random_episodes();

    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));

    $display("Run covered %0d actions (%0d with the spare code), %0d results checked.",
             sent_count, unused_count, checked_count);
    $display({"Peak fill %0d of %0d, %0d full-table refusals, %0d inverted ranges, ",
              "largest removal %0d, %0d mismatches."},
             peak_fill, TABLE_DEPTH, full_refusals, range_refusals,
             max_removed, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
